### rtl/c3z_pkg.sv
// Shared types and constants for the 3x3 zero-border convolution block.
// Used by the top level, the multiply/accumulate pipeline and the checker.
`default_nettype none

package c3z_pkg;

	// Image geometry and pixel format
	localparam int MAX_WIDTH  = 1024;
	localparam int PIXEL_BITS = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int EFF_W      = $clog2(MAX_WIDTH + 2);
	localparam int WID_W      = 11;
	localparam int XW         = ((WID_W > EFF_W) ? WID_W : EFF_W) + 1;
	localparam logic [WID_W-1:0] IMG_WIDTH_RST = 11'd1024;

	// Kernel and arithmetic widths
	localparam int KSIZE      = 3;
	localparam int WEIGHT_W   = 16;
	localparam int ROW_W      = KSIZE * WEIGHT_W;
	localparam int PROD_W     = PIXEL_BITS + 1 + WEIGHT_W;
	localparam int SUM_W      = PROD_W + 4;
	localparam int OUT_W      = 16;
	localparam int DIV_SHIFT  = 3;
	localparam int DIV_BIAS   = (1 << DIV_SHIFT) - 1;

	// Stream and configuration port widths
	localparam int IN_TDATA_W  = ((PIXEL_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int CFG_W       = ROW_W;
	localparam int CFG_IDX_W   = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KTOP  = 2'd0,
		REG_KMID  = 2'd1,
		REG_KBOT  = 2'd2,
		REG_WIDTH = 2'd3
	} cfg_reg_t;

	typedef logic [PIXEL_BITS-1:0] pix_t;

	// Window entry [row*3 + col]; row 0 is the top row, col 0 the left column
	typedef pix_t [KSIZE*KSIZE-1:0] window_t;

	// Kernel rows, index 0 is the top row
	typedef logic [KSIZE-1:0][ROW_W-1:0] kernel_t;

	// Per-item control that travels with the window into the arithmetic
	typedef struct packed {
		logic done;
		logic left_en;
		logic right_en;
	} ctl_t;

endpackage

`default_nettype wire

### rtl/conv3x3_zero_border_div8.sv
// 3x3 convolution with zero border on a raster pixel stream, result divided by 8.
// Top level: frame counters, line memory, window; uses c3z_pkg and c3z_mac.
//
// Usage:
//   Pixels enter on the s_axis channel in raster order, one item per beat:
//   tdata carries the gray value, tuser[0] marks a drain item. After the
//   last pixel of a frame, image_width+1 drain items flush the bottom row;
//   the last result of the frame leaves with m_axis_tlast high.
//   Each result belongs to the pixel image_width+1 items before the item
//   that releases it, and reaches m_axis through the first stage, the window
//   stage and the product, sum and output registers of c3z_mac.
//   Throughput is one item per cycle while the output is not stalled: the
//   line memory is read on accept and written back from the first stage, so
//   one read port and one write port serve every item; a same-address bypass
//   covers one-pixel rows and frame restarts.
//   Kernel rows and image_width are written on the cfg port while the block
//   is idle; writing image_width restarts the frame counters.
//   Reset clears the counters, the window, the kernel and sets the width to
//   1024; the line memory needs no clearing, since the row counters keep
//   unwritten entries out of every sum.
//   When m_axis_tready is low, results back up through the pipeline stages;
//   s_axis_tready drops only once the first stage cannot move.
`default_nettype none

module conv3x3_zero_border_div8 (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [c3z_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [7:0] pixel
	input  logic [0:0]                         s_axis_tuser,  // [0] func
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [c3z_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [15:0] filtered_value
	output logic                               m_axis_tlast,  // frame_done
	input  logic                               cfg_we,
	input  logic [c3z_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [c3z_pkg::CFG_W-1:0]          cfg_data
);
	import c3z_pkg::*;

	// Configuration registers
	logic [ROW_W-1:0] ktop_q;
	logic [ROW_W-1:0] kmid_q;
	logic [ROW_W-1:0] kbot_q;
	logic [WID_W-1:0] width_q;

	// Frame position
	logic [COL_W-1:0] col_q;
	logic [1:0]       rows_q;
	logic [EFF_W-1:0] dcnt_q;

	// Accept-cycle decode
	logic [XW-1:0]    wx;
	logic [EFF_W-1:0] eff_w;
	logic             drain;
	logic             ign;
	logic             clr;
	logic [COL_W-1:0] col_e;
	logic [1:0]       rows_e;
	logic [EFF_W-1:0] dcnt_e;
	logic [EFF_W-1:0] cx;
	logic [EFF_W-1:0] cc;
	logic [EFF_W-1:0] dnew;
	logic [COL_W-1:0] col_n;
	logic [1:0]       rows_n;
	logic [EFF_W-1:0] dcnt_n;
	logic             top_p;
	logic             mid_p;
	logic             res;
	ctl_t             ctl_c;
	logic             accept;
	logic             take;
	logic [COL_W-1:0] addr_c;
	pix_t             botv_c;

	// First stage
	logic             v1_q;
	logic [COL_W-1:0] addr_s1;
	pix_t             botv_s1;
	logic             topp_s1;
	logic             midp_s1;
	logic             res_s1;
	ctl_t             ctl_s1;
	logic             rdy1;
	logic             adv1;

	// Line memory: {two rows back, one row back} per column
	logic [2*PIXEL_BITS-1:0] lmem [MAX_WIDTH];
	logic [2*PIXEL_BITS-1:0] rd_q;
	logic [2*PIXEL_BITS-1:0] bypd_q;
	logic                    byp_q;
	logic [2*PIXEL_BITS-1:0] rd;
	logic [2*PIXEL_BITS-1:0] wr_data;
	pix_t                    older;
	pix_t                    newer;

	// Second stage: window and its control
	window_t          win_q;
	ctl_t             ctl_s2;
	logic             v2_q;
	logic             mac_ready;
	logic [OUT_W-1:0] out_value;

	// Effective width: zero acts as one, oversize clamps to the line length.
	always_comb begin
		wx = XW'(width_q);
		if (wx == '0) begin
			wx = XW'(1);
		end else if (wx > XW'(MAX_WIDTH)) begin
			wx = XW'(MAX_WIDTH);
		end
		eff_w = EFF_W'(wx);
	end

	// Position of the incoming item and the next frame position.
	always_comb begin
		drain  = s_axis_tuser[0];
		ign    = drain && rows_q == 2'd0 && col_q == '0 && dcnt_q == '0;
		clr    = !drain && dcnt_q != '0;
		col_e  = clr ? '0 : col_q;
		rows_e = clr ? 2'd0 : rows_q;
		dcnt_e = clr ? '0 : dcnt_q;

		cx = EFF_W'(col_e);
		if (cx >= eff_w) begin
			cx = eff_w - EFF_W'(1);
		end
		addr_c = cx[COL_W-1:0];
		botv_c = drain ? '0 : s_axis_tdata[PIXEL_BITS-1:0];

		top_p = rows_e[1];
		mid_p = rows_e != 2'd0 && !(drain && dcnt_e >= eff_w);
		res   = rows_e[1] || (rows_e == 2'd1 && cx != '0);

		// The output pixel sits one column left of the incoming one.
		cc             = (cx == '0) ? eff_w - EFF_W'(1) : cx - EFF_W'(1);
		ctl_c.left_en  = cc != '0;
		ctl_c.right_en = (cc + EFF_W'(1)) < eff_w;

		if (cx + EFF_W'(1) >= eff_w) begin
			col_n  = '0;
			rows_n = (rows_e == 2'd3) ? rows_e : rows_e + 2'd1;
		end else begin
			col_n  = COL_W'(cx + EFF_W'(1));
			rows_n = rows_e;
		end

		dnew       = dcnt_e + EFF_W'(1);
		ctl_c.done = drain && dnew > eff_w;
		dcnt_n     = dcnt_e;
		if (drain) begin
			dcnt_n = dnew;
			if (ctl_c.done) begin
				col_n  = '0;
				rows_n = 2'd0;
				dcnt_n = '0;
			end
		end
	end

	// Handshake: the first stage moves when the window stage is free.
	assign rdy1          = !v2_q || mac_ready;
	assign adv1          = v1_q && rdy1;
	assign s_axis_tready = !v1_q || rdy1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign take          = accept && !ign;

	// Configuration and frame position registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ktop_q  <= '0;
			kmid_q  <= '0;
			kbot_q  <= '0;
			width_q <= IMG_WIDTH_RST;
			col_q   <= '0;
			rows_q  <= 2'd0;
			dcnt_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KTOP: begin
					ktop_q <= cfg_data;
				end
				REG_KMID: begin
					kmid_q <= cfg_data;
				end
				REG_KBOT: begin
					kbot_q <= cfg_data;
				end
				REG_WIDTH: begin
					width_q <= cfg_data[WID_W-1:0];
					col_q   <= '0;
					rows_q  <= 2'd0;
					dcnt_q  <= '0;
				end
				default: begin
				end
			endcase
		end else if (take) begin
			col_q  <= col_n;
			rows_q <= rows_n;
			dcnt_q <= dcnt_n;
		end
	end

	// Line memory: read on accept, shift the column down from the first stage.
	always_ff @(posedge clk) begin
		if (adv1) begin
			lmem[addr_s1] <= wr_data;
		end
		if (take) begin
			rd_q   <= lmem[addr_c];
			byp_q  <= adv1 && addr_s1 == addr_c;
			bypd_q <= wr_data;
		end
	end

	assign rd      = byp_q ? bypd_q : rd_q;
	assign older   = rd[2*PIXEL_BITS-1:PIXEL_BITS];
	assign newer   = rd[PIXEL_BITS-1:0];
	assign wr_data = {newer, botv_s1};

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				v1_q <= take;
			end
			if (rdy1) begin
				v2_q <= v1_q && res_s1;
			end
		end
	end

	// First stage payload.
	always_ff @(posedge clk) begin
		if (take) begin
			addr_s1 <= addr_c;
			botv_s1 <= botv_c;
			topp_s1 <= top_p;
			midp_s1 <= mid_p;
			res_s1  <= res;
			ctl_s1  <= ctl_c;
		end
		if (adv1) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Window shifts left; the new right column comes from memory and input.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (adv1) begin
			for (int i = 0; i < KSIZE; i++) begin
				win_q[i*KSIZE]     <= win_q[i*KSIZE+1];
				win_q[i*KSIZE+1]   <= win_q[i*KSIZE+2];
			end
			win_q[KSIZE-1]         <= topp_s1 ? older : '0;
			win_q[2*KSIZE-1]       <= midp_s1 ? newer : '0;
			win_q[KSIZE*KSIZE-1]   <= botv_s1;
		end
	end

	c3z_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2_q),
		.in_ready  (mac_ready),
		.win       (win_q),
		.ctl       (ctl_s2),
		.kern      ({kbot_q, kmid_q, ktop_q}),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (out_value),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_TDATA_W'(out_value);

endmodule

`default_nettype wire

### rtl/c3z_mac.sv
// Weighted 3x3 sum, divide by 8 toward zero and wrap to 16 bits.
// Three registered stages with per-stage flow control; needs c3z_pkg.
`default_nettype none

module c3z_mac (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  c3z_pkg::window_t          win,
	input  c3z_pkg::ctl_t             ctl,
	input  c3z_pkg::kernel_t          kern,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [c3z_pkg::OUT_W-1:0] out_value,
	output logic                      out_last
);
	import c3z_pkg::*;

	logic                     v3_s3;
	logic                     v4_s4;
	logic                     rdy_out;
	logic                     rdy3;
	logic signed [PROD_W-1:0] prod_c  [KSIZE*KSIZE];
	logic signed [PROD_W-1:0] prod_s3 [KSIZE*KSIZE];
	logic                     done_s3;
	logic signed [SUM_W-1:0]  sum_c;
	logic signed [SUM_W-1:0]  sum_s4;
	logic                     done_s4;
	logic        [SUM_W-1:0]  biased;

	// Each stage moves when the one after it is empty or moving on.
	assign rdy_out  = !out_valid || out_ready;
	assign rdy3     = !v4_s4 || rdy_out;
	assign in_ready = !v3_s3 || rdy3;

	// Nine products; the left or right column drops out at the image edge.
	always_comb begin
		for (int i = 0; i < KSIZE; i++) begin
			for (int j = 0; j < KSIZE; j++) begin
				prod_c[i*KSIZE+j] = $signed({1'b0, win[i*KSIZE+j]})
					* $signed(kern[i][j*WEIGHT_W +: WEIGHT_W]);
				if ((j == 0 && !ctl.left_en) || (j == KSIZE - 1 && !ctl.right_en)) begin
					prod_c[i*KSIZE+j] = '0;
				end
			end
		end
	end

	// Sum of the registered products.
	always_comb begin
		sum_c = '0;
		for (int k = 0; k < KSIZE*KSIZE; k++) begin
			sum_c = sum_c + SUM_W'(prod_s3[k]);
		end
	end

	// Truncating division: bias negative sums before the shift.
	assign biased = sum_s4 + (sum_s4[SUM_W-1] ? SUM_W'(DIV_BIAS) : SUM_W'(0));

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_s3     <= 1'b0;
			v4_s4     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_ready) begin
				v3_s3 <= in_valid;
			end
			if (rdy3) begin
				v4_s4 <= v3_s3;
			end
			if (rdy_out) begin
				out_valid <= v4_s4;
			end
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prod_s3 <= prod_c;
			done_s3 <= ctl.done;
		end
		if (rdy3 && v3_s3) begin
			sum_s4  <= sum_c;
			done_s4 <= done_s3;
		end
		if (rdy_out && v4_s4) begin
			out_value <= biased[DIV_SHIFT +: OUT_W];
			out_last  <= done_s4;
		end
	end

endmodule

`default_nettype wire

### rtl/c3z_checker.sv
// Port-level checks for the 3x3 convolution block, bound to its top level.
// Needs c3z_pkg for port widths.
`default_nettype none

module c3z_port_checks (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tready,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [c3z_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                            m_axis_tlast
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its value and frame flag.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// With the output free to move, every stage can move, so input is taken.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid || m_axis_tready |-> s_axis_tready)
		else $error("input blocked while output is free");

	// Leaving reset, no result is offered.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result present right after reset");

endmodule

bind conv3x3_zero_border_div8 c3z_port_checks u_c3z_port_checks (.*);

`default_nettype wire
